// ----- hdl/tfbs_pkg.sv -----
`default_nettype none
package tfbs_pkg;

  localparam int unsigned CNT_W   = 16;
  localparam int unsigned SUM_W   = 16;
  localparam int unsigned BIT_W   = 5;
  localparam int unsigned QUEUE_D = 2;

  localparam logic [3:0] PULSE_ONE  = 4'd15;
  localparam logic [3:0] PULSE_ZERO = 4'd5;

  localparam logic [BIT_W-1:0] LAST_BIT_PLAIN = BIT_W'(7);
  localparam logic [BIT_W-1:0] LAST_BIT_GEN   = BIT_W'(23);

  typedef enum logic [1:0] {
    SEL_DATA   = 2'd0,
    SEL_SUM_LO = 2'd1,
    SEL_SUM_HI = 2'd2
  } byte_sel_e;

  typedef enum logic [4:0] {
    PH_ADDR = 5'b00001,
    PH_LEN  = 5'b00010,
    PH_NAME = 5'b00100,
    PH_DATA = 5'b01000,
    PH_SUM  = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [7:0]       data;
    logic             gen;
    logic             done;
    logic [SUM_W-1:0] sum;
  } job_t;

endpackage
`default_nettype wire

// ----- hdl/tfbs_front.sv -----
`default_nettype none
module tfbs_front
  import tfbs_pkg::*;
#(
  parameter int unsigned NAME_BYTES = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic       cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] byte_in_i,
  output logic            push_o,
  input  wire logic       push_ready_i,
  output job_t            job_o
);

  logic             from_input_q;
  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] length_q, length_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [SUM_W:0]   sum_raw;
  logic [SUM_W-1:0] sum_add;
  logic [CNT_W-1:0] count_inc;
  logic             gen, done;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = push_ready_i;
  assign push_o      = in_valid_i && push_ready_i;

  assign sum_raw   = {1'b0, sum_q} + {{(SUM_W - 7){1'b0}}, byte_in_i};
  assign sum_add   = sum_raw[SUM_W] ? (sum_raw[SUM_W-1:0] + SUM_W'(1)) : sum_raw[SUM_W-1:0];
  assign count_inc = count_q + CNT_W'(1);

  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    length_d = length_q;
    sum_d    = sum_q;
    gen      = 1'b0;
    done     = 1'b0;
    case (phase_q)
      PH_LEN: begin
        if (count_q == '0) begin
          length_d = {{(CNT_W - 8){1'b0}}, byte_in_i};
          count_d  = CNT_W'(1);
        end else begin
          length_d = {byte_in_i, length_q[7:0]};
          phase_d  = PH_NAME;
          count_d  = '0;
        end
      end
      PH_NAME: begin
        count_d = count_inc;
        if (count_inc >= CNT_W'(NAME_BYTES)) begin
          count_d = '0;
          if (length_q == '0) begin
            phase_d = PH_SUM;
            gen     = !from_input_q;
          end else begin
            phase_d = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        sum_d   = sum_add;
        count_d = count_inc;
        if (count_inc == length_q) begin
          count_d = '0;
          phase_d = PH_SUM;
          gen     = !from_input_q;
        end
      end
      PH_SUM: begin
        if (count_q == '0) begin
          count_d = CNT_W'(1);
        end else begin
          done = 1'b1;
        end
      end
      default: begin
        if (count_q == '0) begin
          count_d = CNT_W'(1);
        end else begin
          phase_d = PH_LEN;
          count_d = '0;
        end
      end
    endcase
    if (gen) begin
      done = 1'b1;
    end
    if (done) begin
      phase_d  = PH_ADDR;
      count_d  = '0;
      length_d = '0;
      sum_d    = '0;
    end
  end

  always_comb begin
    job_o.data = byte_in_i;
    job_o.gen  = gen;
    job_o.done = done;
    job_o.sum  = (phase_q == PH_DATA) ? sum_add : sum_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      from_input_q <= 1'b0;
      phase_q      <= PH_ADDR;
      count_q      <= '0;
      length_q     <= '0;
      sum_q        <= '0;
    end else begin
      if (cfg_valid_i) begin
        from_input_q <= cfg_data_i;
      end
      if (push_o) begin
        phase_q  <= phase_d;
        count_q  <= count_d;
        length_q <= length_d;
        sum_q    <= sum_d;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/tfbs_queue.sv -----
`default_nettype none
module tfbs_queue
  import tfbs_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  output logic      push_ready_o,
  input  wire job_t job_i,
  output logic      head_valid_o,
  output job_t      head_o,
  input  wire logic pop_i
);

  localparam int unsigned PTR_W = $clog2(QUEUE_D);

  job_t             mem_q [QUEUE_D];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [PTR_W:0]   cnt_q;

  assign push_ready_o = (cnt_q != (PTR_W + 1)'(QUEUE_D));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(QUEUE_D - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(QUEUE_D - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (PTR_W + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (PTR_W + 1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/tfbs_back.sv -----
`default_nettype none
module tfbs_back
  import tfbs_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  head_valid_i,
  input  wire job_t  head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output logic       bit_out_o,
  output logic [3:0] pulse_length_o,
  output logic       last_o,
  output logic       frame_done_o
);

  logic [BIT_W-1:0] idx_q;
  logic             valid_q;
  logic             bit_q, last_q, done_q;
  logic             emit, last_bit, cur_bit;
  logic [7:0]       sel_byte;
  byte_sel_e        sel;

  assign emit     = head_valid_i && (!valid_q || out_ready_i);
  assign last_bit = head_i.gen ? (idx_q == LAST_BIT_GEN) : (idx_q == LAST_BIT_PLAIN);
  assign pop_o    = emit && last_bit;
  assign sel      = byte_sel_e'(idx_q[4:3]);

  always_comb begin
    case (sel)
      SEL_DATA:   sel_byte = head_i.data;
      SEL_SUM_LO: sel_byte = head_i.sum[7:0];
      SEL_SUM_HI: sel_byte = head_i.sum[15:8];
      default:    sel_byte = head_i.data;
    endcase
  end

  assign cur_bit = sel_byte[idx_q[2:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (emit) begin
        valid_q <= 1'b1;
        idx_q   <= last_bit ? '0 : idx_q + BIT_W'(1);
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      bit_q  <= cur_bit;
      last_q <= last_bit;
      done_q <= last_bit && head_i.done;
    end
  end

  assign out_valid_o    = valid_q;
  assign bit_out_o      = bit_q;
  assign pulse_length_o = bit_q ? PULSE_ONE : PULSE_ZERO;
  assign last_o         = last_q;
  assign frame_done_o   = done_q;

endmodule
`default_nettype wire

// ----- hdl/tape_frame_bit_serializer.sv -----
`default_nettype none
// cassette frame serializer: bytes in (address, length, name, data, checksum),
// one bit per output item, lsb first, with pulse length 15 for one, 5 for zero.
// every byte becomes 8 output items, one per cycle unless out_ready_i is low;
// in generating mode the final data byte (name byte at length 0) becomes 24
// (the byte, then the low and high checksum). bytes wait in a 2-entry job queue
// while it has room; the bit serializer sets the sustained rate. the user must
// write the checksum mode register through cfg only while idle; not enforced.
module tape_frame_bit_serializer
  import tfbs_pkg::*;
#(
  parameter int unsigned NAME_BYTES = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic       cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] byte_in_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            bit_out_o,
  output logic [3:0]      pulse_length_o,
  output logic            last_o,
  output logic            frame_done_o
);

  logic push, push_ready, head_valid, pop;
  job_t job, head;

  tfbs_front #(
    .NAME_BYTES(NAME_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .byte_in_i    (byte_in_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .job_o        (job)
  );

  tfbs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .job_i        (job),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  tfbs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .bit_out_o      (bit_out_o),
    .pulse_length_o (pulse_length_o),
    .last_o         (last_o),
    .frame_done_o   (frame_done_o)
  );

endmodule
`default_nettype wire
